>>> src/pkcf_pkg.sv
// ----------------------------------------------------------------------------
// pkcf_pkg
// Types, constants and table functions shared by the kinematic cut filter.
// ----------------------------------------------------------------------------
package pkcf_pkg;

    localparam int CORDIC_STEPS_DEF = 20;

    // Angles and logarithms are carried in units of 2^-24.
    localparam logic signed [31:0] PI_Q24  = 32'sd52707179;
    localparam logic [39:0]        LN2_Q24 = 40'd11629080;

    // Width of the hyperbolic datapath; the mantissa sum stays below 2^33.
    localparam int HYP_W = 36;

    typedef enum logic [2:0] {
        CFG_ETA_LOW   = 3'd0,
        CFG_ETA_HIGH  = 3'd1,
        CFG_PHI_LOW   = 3'd2,
        CFG_PHI_HIGH  = 3'd3,
        CFG_MOM_LOW   = 3'd4,
        CFG_MOM_HIGH  = 3'd5,
        CFG_RADIUS    = 3'd6,
        CFG_CODE_PAIR = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] res;
    } t_sqrt;

    typedef struct packed {
        logic signed [63:0] cx;
        logic signed [63:0] cy;
        logic signed [31:0] z;
    } t_circ;

    typedef struct packed {
        logic signed [HYP_W-1:0] cx;
        logic signed [HYP_W-1:0] cy;
        logic signed [31:0]      z;
    } t_hyp;

    typedef struct packed {
        logic [63:0] s;
        logic [63:0] st;
        logic [31:0] az;
        logic        zneg;
        logic        zpos;
        logic        vfail;
        logic        code_fail;
    } t_ctx;

    typedef struct packed {
        logic zneg;
        logic zpos;
        logic vfail;
        logic code_fail;
        logic s_zero;
        logic st_zero;
        logic mom_fail;
    } t_flags;

    function automatic logic signed [31:0] atan_val(input int i);
        logic signed [31:0] v;
        case (i)
            0:       v = 32'sd13176795;
            1:       v = 32'sd7778716;
            2:       v = 32'sd4110060;
            3:       v = 32'sd2086331;
            4:       v = 32'sd1047214;
            5:       v = 32'sd524117;
            6:       v = 32'sd262123;
            7:       v = 32'sd131069;
            default: v = (i <= 24) ? (32'sd1 <<< (24 - i)) : 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] atanh_val(input int i);
        logic signed [31:0] v;
        case (i)
            0:       v = 32'sd0;
            1:       v = 32'sd9215828;
            2:       v = 32'sd4285116;
            3:       v = 32'sd2108178;
            4:       v = 32'sd1049945;
            5:       v = 32'sd524459;
            6:       v = 32'sd262165;
            7:       v = 32'sd131075;
            default: v = (i <= 24) ? (32'sd1 <<< (24 - i)) : 32'sd0;
        endcase
        return v;
    endfunction

    // Shift used by hyperbolic iteration n; shifts 4, 13 and 40 are taken twice.
    function automatic int hyp_shift(input int n);
        int  sh;
        bit  again;
        sh    = 1;
        again = 1'b0;
        for (int j = 0; j < n; j++) begin
            if ((sh == 4 || sh == 13 || sh == 40) && !again) begin
                again = 1'b1;
            end else begin
                again = 1'b0;
                sh++;
            end
        end
        return sh;
    endfunction

endpackage

>>> src/pkcf_delay.sv
// ----------------------------------------------------------------------------
// pkcf_delay
// Shift line that keeps side data aligned with the arithmetic chains.
// ----------------------------------------------------------------------------
module pkcf_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_line [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_data;
            for (int j = 1; j < D; j++) begin
                r_line[j] <= r_line[j-1];
            end
        end
    end

    assign o_data = r_line[D-1];

endmodule

>>> src/pkcf_sqrt_cell.sv
// ----------------------------------------------------------------------------
// pkcf_sqrt_cell
// One digit of the restoring integer square root.
// ----------------------------------------------------------------------------
module pkcf_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  pkcf_pkg::t_sqrt i_d,
    output pkcf_pkg::t_sqrt o_d
);

    localparam logic [63:0] TRIAL_BIT = 64'd1 << (62 - 2 * STEP);

    pkcf_pkg::t_sqrt r_d;
    pkcf_pkg::t_sqrt n_d;
    logic [63:0]     trial;

    always_comb begin
        trial = i_d.res + TRIAL_BIT;
        if (i_d.v >= trial) begin
            n_d.v   = i_d.v - trial;
            n_d.res = (i_d.res >> 1) + TRIAL_BIT;
        end else begin
            n_d.v   = i_d.v;
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

>>> src/pkcf_circ_cell.sv
// ----------------------------------------------------------------------------
// pkcf_circ_cell
// One circular vectoring rotation of the azimuth chain.
// ----------------------------------------------------------------------------
module pkcf_circ_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  pkcf_pkg::t_circ i_d,
    output pkcf_pkg::t_circ o_d
);

    localparam logic signed [31:0] ANG = pkcf_pkg::atan_val(STEP);

    pkcf_pkg::t_circ    r_d;
    pkcf_pkg::t_circ    n_d;
    logic signed [63:0] dx;
    logic signed [63:0] dy;

    always_comb begin
        dx = $signed(i_d.cy) >>> STEP;
        dy = $signed(i_d.cx) >>> STEP;
        if (!i_d.cy[63]) begin
            n_d.cx = i_d.cx + dx;
            n_d.cy = i_d.cy - dy;
            n_d.z  = i_d.z + ANG;
        end else begin
            n_d.cx = i_d.cx - dx;
            n_d.cy = i_d.cy + dy;
            n_d.z  = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

>>> src/pkcf_hyp_cell.sv
// ----------------------------------------------------------------------------
// pkcf_hyp_cell
// One hyperbolic vectoring rotation of the logarithm chain.
// ----------------------------------------------------------------------------
module pkcf_hyp_cell #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  pkcf_pkg::t_hyp i_d,
    output pkcf_pkg::t_hyp o_d
);

    localparam int                 SH  = pkcf_pkg::hyp_shift(STEP);
    localparam logic signed [31:0] ANG = pkcf_pkg::atanh_val(SH);

    pkcf_pkg::t_hyp                   r_d;
    pkcf_pkg::t_hyp                   n_d;
    logic signed [pkcf_pkg::HYP_W-1:0] dx;
    logic signed [pkcf_pkg::HYP_W-1:0] dy;

    always_comb begin
        dx = $signed(i_d.cy) >>> SH;
        dy = $signed(i_d.cx) >>> SH;
        if (!i_d.cy[pkcf_pkg::HYP_W-1]) begin
            n_d.cx = i_d.cx - dx;
            n_d.cy = i_d.cy - dy;
            n_d.z  = i_d.z + ANG;
        end else begin
            n_d.cx = i_d.cx + dx;
            n_d.cy = i_d.cy + dy;
            n_d.z  = i_d.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

>>> src/particle_kinematic_cut_filter.sv
// Throughput: one transaction per cycle while the output is not stalled; the 32-cell
// square root chain and the CORDIC cell chains are fully pipelined, each cell a
// register stage. A held result with stall high freezes the whole pipeline and
// raises the input stall.
// Reset clears the valid line and loads the cut registers with their defaults.
// ----------------------------------------------------------------------------
// particle_kinematic_cut_filter
// Momentum, pseudorapidity and azimuth cuts on a stream of particles.
// ----------------------------------------------------------------------------
module particle_kinematic_cut_filter #(
    parameter int CORDIC_STEPS = pkcf_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_mom_x,
    input  logic signed [31:0] i_mom_y,
    input  logic signed [31:0] i_mom_z,
    input  logic signed [31:0] i_particle_code,
    input  logic               i_vertex_present,
    input  logic signed [31:0] i_vertex_x,
    input  logic signed [31:0] i_vertex_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_accepted
);

    localparam int N   = CORDIC_STEPS;
    localparam int LAT = N + 52;

    // ---------------- configuration ----------------
    logic signed [19:0] r_eta_low, r_eta_high;
    logic signed [15:0] r_phi_low, r_phi_high;
    logic [32:0]        r_mom_low, r_mom_high;
    logic [31:0]        r_radius;
    logic [63:0]        r_code_pair;
    logic [63:0]        r_rad_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_low   <= -20'sd524288;
            r_eta_high  <= 20'sd524287;
            r_phi_low   <= -16'sd25736;
            r_phi_high  <= 16'sd25736;
            r_mom_low   <= '0;
            r_mom_high  <= '1;
            r_radius    <= '1;
            r_code_pair <= '0;
        end else if (i_cfg_we) begin
            unique case (pkcf_pkg::t_cfg_idx'(i_cfg_idx))
                pkcf_pkg::CFG_ETA_LOW:   r_eta_low   <= i_cfg_data[19:0];
                pkcf_pkg::CFG_ETA_HIGH:  r_eta_high  <= i_cfg_data[19:0];
                pkcf_pkg::CFG_PHI_LOW:   r_phi_low   <= i_cfg_data[15:0];
                pkcf_pkg::CFG_PHI_HIGH:  r_phi_high  <= i_cfg_data[15:0];
                pkcf_pkg::CFG_MOM_LOW:   r_mom_low   <= i_cfg_data[32:0];
                pkcf_pkg::CFG_MOM_HIGH:  r_mom_high  <= i_cfg_data[32:0];
                pkcf_pkg::CFG_RADIUS:    r_radius    <= i_cfg_data[31:0];
                pkcf_pkg::CFG_CODE_PAIR: r_code_pair <= i_cfg_data;
            endcase
        end
    end

    // The squared limit only changes on configuration writes.
    always_ff @(posedge i_clk) begin
        r_rad_sq <= {32'd0, r_radius} * {32'd0, r_radius};
    end

    // ---------------- pipeline control ----------------
    logic           adv;
    logic [1:LAT]   r_vld;

    assign adv     = !(r_vld[LAT] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {i_valid, r_vld[1:LAT-1]};
        end
    end

    // ---------------- stage 1: magnitudes and code list ----------------
    logic [31:0]        r_ax_s1, r_ay_s1, r_az_s1, r_vx_s1, r_vy_s1;
    logic signed [31:0] r_px_s1, r_py_s1;
    logic               r_zneg_s1, r_zpos_s1, r_vpres_s1, r_cfail_s1;
    logic [31:0]        c0, c1;
    logic               n_cfail;

    always_comb begin
        c0      = r_code_pair[31:0];
        c1      = r_code_pair[63:32];
        n_cfail = ((c0 | c1) != 32'd0) &&
                  !(((c0 != 32'd0) && (i_particle_code == c0)) ||
                    ((c1 != 32'd0) && (i_particle_code == c1)));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax_s1    <= i_mom_x[31] ? (~i_mom_x + 32'd1) : i_mom_x;
            r_ay_s1    <= i_mom_y[31] ? (~i_mom_y + 32'd1) : i_mom_y;
            r_az_s1    <= i_mom_z[31] ? (~i_mom_z + 32'd1) : i_mom_z;
            r_vx_s1    <= i_vertex_x[31] ? (~i_vertex_x + 32'd1) : i_vertex_x;
            r_vy_s1    <= i_vertex_y[31] ? (~i_vertex_y + 32'd1) : i_vertex_y;
            r_px_s1    <= i_mom_x;
            r_py_s1    <= i_mom_y;
            r_zneg_s1  <= i_mom_z[31];
            r_zpos_s1  <= !i_mom_z[31] && (i_mom_z != 32'sd0);
            r_vpres_s1 <= i_vertex_present;
            r_cfail_s1 <= n_cfail;
        end
    end

    // ---------------- stages 2 to 4: squares and sums ----------------
    logic [63:0] r_sqx_s2, r_sqy_s2, r_sqz_s2, r_vsx_s2, r_vsy_s2;
    logic [31:0] r_az_s2, r_az_s3;
    logic        r_zneg_s2, r_zpos_s2, r_vpres_s2, r_cfail_s2;
    logic [63:0] r_st_s3, r_sqz_s3, r_vsum_s3;
    logic        r_zneg_s3, r_zpos_s3, r_vpres_s3, r_cfail_s3;
    pkcf_pkg::t_ctx r_ctx_s4;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqx_s2   <= {32'd0, r_ax_s1} * {32'd0, r_ax_s1};
            r_sqy_s2   <= {32'd0, r_ay_s1} * {32'd0, r_ay_s1};
            r_sqz_s2   <= {32'd0, r_az_s1} * {32'd0, r_az_s1};
            r_vsx_s2   <= {32'd0, r_vx_s1} * {32'd0, r_vx_s1};
            r_vsy_s2   <= {32'd0, r_vy_s1} * {32'd0, r_vy_s1};
            r_az_s2    <= r_az_s1;
            r_zneg_s2  <= r_zneg_s1;
            r_zpos_s2  <= r_zpos_s1;
            r_vpres_s2 <= r_vpres_s1;
            r_cfail_s2 <= r_cfail_s1;

            r_st_s3    <= r_sqx_s2 + r_sqy_s2;
            r_vsum_s3  <= r_vsx_s2 + r_vsy_s2;
            r_sqz_s3   <= r_sqz_s2;
            r_az_s3    <= r_az_s2;
            r_zneg_s3  <= r_zneg_s2;
            r_zpos_s3  <= r_zpos_s2;
            r_vpres_s3 <= r_vpres_s2;
            r_cfail_s3 <= r_cfail_s2;

            r_ctx_s4.s         <= r_st_s3 + r_sqz_s3;
            r_ctx_s4.st        <= r_st_s3;
            r_ctx_s4.az        <= r_az_s3;
            r_ctx_s4.zneg      <= r_zneg_s3;
            r_ctx_s4.zpos      <= r_zpos_s3;
            r_ctx_s4.vfail     <= r_vpres_s3 && (r_vsum_s3 > r_rad_sq);
            r_ctx_s4.code_fail <= r_cfail_s3;
        end
    end

    // ---------------- stages 5 to 9: scale s by 4^k ----------------
    logic [63:0] snw [0:5];
    logic [4:0]  snk [0:5];

    assign snw[0] = r_ctx_s4.s;
    assign snk[0] = 5'd0;

    for (genvar j = 0; j < 5; j++) begin : g_snorm
        localparam int PAIRS = 16 >> j;
        logic [63:0] r_w;
        logic [4:0]  r_k;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (snw[j][63 -: 2*PAIRS] == '0) begin
                    r_w <= snw[j] << (2 * PAIRS);
                    r_k <= snk[j] + 5'(PAIRS);
                end else begin
                    r_w <= snw[j];
                    r_k <= snk[j];
                end
            end
        end
        assign snw[j+1] = r_w;
        assign snk[j+1] = r_k;
    end

    // ---------------- stages 10 to 41: square root cells ----------------
    pkcf_pkg::t_sqrt sq_d [0:32];

    assign sq_d[0] = '{v: snw[5], res: 64'd0};

    for (genvar j = 0; j < 32; j++) begin : g_sqrt
        pkcf_sqrt_cell #(.STEP(j)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (sq_d[j]),
            .o_d   (sq_d[j+1])
        );
    end

    pkcf_pkg::t_ctx ctx_s41;
    logic [4:0]     k_s41;

    pkcf_delay #(.W($bits(pkcf_pkg::t_ctx)), .D(37)) u_ctx_dly (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (r_ctx_s4),
        .o_data (ctx_s41)
    );

    pkcf_delay #(.W(5), .D(32)) u_k_dly (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (snk[5]),
        .o_data (k_s41)
    );

    // ---------------- stages 42 to 44: |p| window ----------------
    logic [31:0]      r_p0_s42, r_p0_s43;
    logic [63:0]      r_a_s42, r_t_s42, r_s_s42, r_s_s43, r_p0sq_s43;
    pkcf_pkg::t_flags r_fl_s42, r_fl_s43, r_fl_s44;
    pkcf_pkg::t_flags n_fl_s44;
    logic             exact;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p0_s42          <= 32'(sq_d[32].res >> k_s41);
            r_a_s42           <= {32'd0, sq_d[32].res[31:0]} + ({32'd0, ctx_s41.az} << k_s41);
            r_t_s42           <= ctx_s41.st << {k_s41, 1'b0};
            r_s_s42           <= ctx_s41.s;
            r_fl_s42.zneg     <= ctx_s41.zneg;
            r_fl_s42.zpos     <= ctx_s41.zpos;
            r_fl_s42.vfail    <= ctx_s41.vfail;
            r_fl_s42.code_fail <= ctx_s41.code_fail;
            r_fl_s42.s_zero   <= (ctx_s41.s == 64'd0);
            r_fl_s42.st_zero  <= (ctx_s41.st == 64'd0);
            r_fl_s42.mom_fail <= 1'b0;

            r_p0sq_s43 <= {32'd0, r_p0_s42} * {32'd0, r_p0_s42};
            r_p0_s43   <= r_p0_s42;
            r_s_s43    <= r_s_s42;
            r_fl_s43   <= r_fl_s42;
        end
    end

    assign exact = (r_p0sq_s43 == r_s_s43);

    always_comb begin
        n_fl_s44          = r_fl_s43;
        n_fl_s44.mom_fail = ({1'b0, r_p0_s43} < r_mom_low) ||
                            ({1'b0, r_p0_s43} > r_mom_high) ||
                            (({1'b0, r_p0_s43} == r_mom_high) && !exact);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fl_s44 <= n_fl_s44;
        end
    end

    // ---------------- stages 43 to 48: log argument normalization ----------------
    logic [63:0] lwa [0:6];
    logic [63:0] lwt [0:6];
    logic [5:0]  lca [0:6];
    logic [5:0]  lct [0:6];

    assign lwa[0] = r_a_s42;
    assign lwt[0] = r_t_s42;
    assign lca[0] = 6'd0;
    assign lct[0] = 6'd0;

    for (genvar j = 0; j < 6; j++) begin : g_lnorm
        localparam int AMT = 32 >> j;
        logic [63:0] r_wa, r_wt;
        logic [5:0]  r_ca, r_ct;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (lwa[j][63 -: AMT] == '0) begin
                    r_wa <= lwa[j] << AMT;
                    r_ca <= lca[j] + 6'(AMT);
                end else begin
                    r_wa <= lwa[j];
                    r_ca <= lca[j];
                end
                if (lwt[j][63 -: AMT] == '0) begin
                    r_wt <= lwt[j] << AMT;
                    r_ct <= lct[j] + 6'(AMT);
                end else begin
                    r_wt <= lwt[j];
                    r_ct <= lct[j];
                end
            end
        end
        assign lwa[j+1] = r_wa;
        assign lwt[j+1] = r_wt;
        assign lca[j+1] = r_ca;
        assign lct[j+1] = r_ct;
    end

    // ---------------- stages 49 to 48+N: hyperbolic cells ----------------
    localparam int HW = pkcf_pkg::HYP_W;
    localparam logic signed [HW-1:0] ONE_Q30 = HW'(64'd1 << 30);

    pkcf_pkg::t_hyp ha [0:N];
    pkcf_pkg::t_hyp ht [0:N];
    logic [11:0]    e_s48, e_dly;

    // The mantissa holds the leading one at bit 30 and 30 fraction bits.
    assign ha[0] = '{cx: HW'(lwa[6][63:33]) + ONE_Q30,
                     cy: HW'(lwa[6][63:33]) - ONE_Q30, z: 32'sd0};
    assign ht[0] = '{cx: HW'(lwt[6][63:33]) + ONE_Q30,
                     cy: HW'(lwt[6][63:33]) - ONE_Q30, z: 32'sd0};
    assign e_s48 = {6'd63 - lca[6], 6'd63 - lct[6]};

    for (genvar j = 0; j < N; j++) begin : g_hyp
        pkcf_hyp_cell #(.STEP(j)) u_cell_a (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (ha[j]),
            .o_d   (ha[j+1])
        );
        pkcf_hyp_cell #(.STEP(j)) u_cell_t (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (ht[j]),
            .o_d   (ht[j+1])
        );
    end

    pkcf_delay #(.W(12), .D(N)) u_exp_dly (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (e_s48),
        .o_data (e_dly)
    );

    // ---------------- azimuth chain, stages 2 to 3+N ----------------
    pkcf_pkg::t_circ    cd [0:N];
    pkcf_pkg::t_circ    r_rot_s2;
    logic signed [63:0] rx, ry;
    logic signed [31:0] rz;
    logic signed [31:0] phi_c;
    logic               r_phi_fail;
    logic               phi_fail_dly;

    // A left half-plane vector is turned by pi before the rotations.
    always_comb begin
        rx = 64'(r_px_s1);
        ry = 64'(r_py_s1);
        rz = 32'sd0;
        if (r_px_s1[31]) begin
            rz = r_py_s1[31] ? -pkcf_pkg::PI_Q24 : pkcf_pkg::PI_Q24;
            rx = -rx;
            ry = -ry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rot_s2 <= '{cx: rx <<< 28, cy: ry <<< 28, z: rz};
        end
    end

    assign cd[0] = r_rot_s2;

    for (genvar j = 0; j < N; j++) begin : g_circ
        pkcf_circ_cell #(.STEP(j)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (cd[j]),
            .o_d   (cd[j+1])
        );
    end

    assign phi_c = (cd[N].z + 32'sd1024) >>> 11;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_phi_fail <= (phi_c < 32'(r_phi_low)) || (phi_c > 32'(r_phi_high));
        end
    end

    pkcf_delay #(.W(1), .D(48)) u_phi_dly (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (r_phi_fail),
        .o_data (phi_fail_dly)
    );

    // ---------------- stages 49+N to 52+N: eta and decision ----------------
    logic signed [39:0] r_lna, r_lnt, r_e24;
    logic signed [19:0] r_eta;
    pkcf_pkg::t_flags   fl_dly, r_fl_eta;
    logic signed [39:0] e_clip;
    logic [26:0]        mag;
    logic signed [19:0] n_eta;
    logic               eta_fail, phi_fail, n_acc;
    logic               r_out_bypass;

    pkcf_delay #(.W($bits(pkcf_pkg::t_flags)), .D(N + 6)) u_fl_dly (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_data (r_fl_s44),
        .o_data (fl_dly)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lna <= $signed(40'(e_dly[11:6]) * pkcf_pkg::LN2_Q24) + (40'(ha[N].z) <<< 1);
            r_lnt <= $signed(40'(e_dly[5:0]) * pkcf_pkg::LN2_Q24) + (40'(ht[N].z) <<< 1);
            r_e24 <= (r_lna <<< 1) - r_lnt;
        end
    end

    always_comb begin
        e_clip = r_e24[39] ? 40'sd0 : r_e24;
        mag    = 27'((e_clip + 40'sd4096) >>> 13);
        if (fl_dly.s_zero) begin
            n_eta = 20'sd0;
        end else if (fl_dly.st_zero) begin
            n_eta = fl_dly.zpos ? 20'sd524287 : -20'sd524288;
        end else if (fl_dly.zneg) begin
            n_eta = (mag > 27'd524288) ? -20'sd524288 : -$signed(20'(mag));
        end else begin
            n_eta = (mag > 27'd524287) ? 20'sd524287 : $signed(20'(mag));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_eta    <= n_eta;
            r_fl_eta <= fl_dly;
        end
    end

    // Without transverse momentum the azimuth is taken as zero.
    always_comb begin
        eta_fail = (r_eta < r_eta_low) || (r_eta > r_eta_high);
        if (r_fl_eta.st_zero) begin
            phi_fail = (r_phi_low > 16'sd0) || (r_phi_high < 16'sd0);
        end else begin
            phi_fail = phi_fail_dly;
        end
        n_acc = r_fl_eta.vfail ||
                (!r_fl_eta.code_fail && !r_fl_eta.mom_fail && !eta_fail && !phi_fail);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_accepted   <= n_acc;
            r_out_bypass <= r_fl_eta.vfail;
        end
    end

    // ---------------- checks ----------------
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld) && $stable(o_accepted))
        else $error("pipeline moved while the output was stalled");

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LAT] && r_out_bypass |-> o_accepted)
        else $error("far vertex particle was rejected");

    a_zero_mom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[42] && (r_s_s42 == 64'd0) |-> (r_p0_s42 == 32'd0))
        else $error("zero momentum gave a nonzero magnitude");

endmodule

>>> verif/pkcf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pkcf_checker
// Watches the configuration port and both channels of the cut filter,
// predicts the accept flag of every particle and compares it in order.
// ----------------------------------------------------------------------------
module pkcf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [31:0] i_mom_x,
    input  logic [31:0] i_mom_y,
    input  logic [31:0] i_mom_z,
    input  logic [31:0] i_particle_code,
    input  logic        i_vertex_present,
    input  logic [31:0] i_vertex_x,
    input  logic [31:0] i_vertex_y,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_accepted,
    output int          o_errors,
    output int          o_pending,
    output int          o_n_pass,
    output int          o_n_reject
);

    localparam int     STEPS     = pkcf_pkg::CORDIC_STEPS_DEF;
    localparam longint HALF_TURN = 52707179;
    localparam longint LOG_TWO   = 11629080;
    localparam longint ATAN_HEAD [8] = '{13176795, 7778716, 4110060, 2086331,
                                         1047214, 524117, 262123, 131069};
    localparam longint ATANH_HEAD [8] = '{0, 9215828, 4285116, 2108178,
                                          1049945, 524459, 262165, 131075};

    longint     eta_lo, eta_hi, phi_lo, phi_hi;
    bit [63:0]  mom_lo, mom_hi, rad_lim;
    bit [31:0]  code0, code1;
    bit         accept_q [$];

    function automatic longint angle_step(input bit hyper, input int i);
        if (i < 8) return hyper ? ATANH_HEAD[i] : ATAN_HEAD[i];
        if (i <= 24) return longint'(1) << (24 - i);
        return 0;
    endfunction

    function automatic bit [63:0] sqrt_floor(input bit [63:0] v);
        bit [63:0] res, b;
        res = 0;
        b   = 64'd1 << 62;
        for (int n = 0; n < 32; n++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Natural log in 2^-24 units via hyperbolic vectoring on the mantissa.
    function automatic longint log_q24(input bit [63:0] v);
        int        e, sh;
        bit        again;
        bit [63:0] mq;
        longint    cx, cy, dx, dy, z;
        e = 63;
        while (e > 0 && !v[e]) e--;
        mq    = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        cx    = longint'(mq) + (longint'(1) << 30);
        cy    = longint'(mq) - (longint'(1) << 30);
        z     = 0;
        sh    = 1;
        again = 0;
        for (int n = 0; n < STEPS; n++) begin
            dx = cy >>> sh;
            dy = cx >>> sh;
            if (cy >= 0) begin
                cx -= dx; cy -= dy; z += angle_step(1'b1, sh);
            end else begin
                cx += dx; cy += dy; z -= angle_step(1'b1, sh);
            end
            if ((sh == 4 || sh == 13 || sh == 40) && !again) begin
                again = 1;
            end else begin
                again = 0;
                sh++;
            end
        end
        return longint'(e) * LOG_TWO + 2 * z;
    endfunction

    function automatic longint azimuth_q24(input longint x, input longint y);
        longint z, cx, cy, dx, dy;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            x = -x;
            y = -y;
        end
        cx = x <<< 28;
        cy = y <<< 28;
        for (int i = 0; i < STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy >= 0) begin
                cx += dx; cy -= dy; z += angle_step(1'b0, i);
            end else begin
                cx -= dx; cy += dy; z -= angle_step(1'b0, i);
            end
        end
        return z;
    endfunction

    function automatic bit particle_passes(input logic [31:0] mx, my, mz, code,
                                           input logic vp, input logic [31:0] vx, vy);
        longint    px, py, pz, eta, phi, e24, mag;
        bit [63:0] ax, ay, az, avx, avy, st, s, r, p0, sh;
        int        k;
        bit        exact, pass;
        px = longint'($signed(mx));
        py = longint'($signed(my));
        pz = longint'($signed(mz));
        if (vp) begin
            avx = (longint'($signed(vx)) < 0) ? -longint'($signed(vx)) : longint'($signed(vx));
            avy = (longint'($signed(vy)) < 0) ? -longint'($signed(vy)) : longint'($signed(vy));
            // Far-away vertex: cuts do not apply.
            if (avx * avx + avy * avy > rad_lim * rad_lim) return 1'b1;
        end
        if ((code0 | code1) != 0 &&
            !((code0 != 0 && code == code0) || (code1 != 0 && code == code1)))
            return 1'b0;
        ax = (px < 0) ? -px : px;
        ay = (py < 0) ? -py : py;
        az = (pz < 0) ? -pz : pz;
        st = ax * ax + ay * ay;
        s  = st + az * az;
        p0 = 0; exact = 1; eta = 0; phi = 0; k = 0;
        if (s != 0) begin
            sh = s;
            while (k < 31 && sh[63:62] == 2'b00) begin
                sh = sh << 2;
                k++;
            end
            r     = sqrt_floor(sh);
            p0    = r >> k;
            exact = (p0 * p0 == s);
            if (st == 0) begin
                eta = (pz > 0) ? 524287 : -524288;
            end else begin
                e24 = 2 * log_q24(r + (az << k)) - log_q24(st << (2 * k));
                if (e24 < 0) e24 = 0;
                mag = (e24 + 4096) >>> 13;
                if (pz < 0) eta = -((mag > 524288) ? 524288 : mag);
                else        eta = (mag > 524287) ? 524287 : mag;
                phi = (azimuth_q24(px, py) + 1024) >>> 11;
            end
        end
        pass = 1'b1;
        if (p0 < mom_lo) pass = 1'b0;
        if (p0 > mom_hi || (p0 == mom_hi && !exact)) pass = 1'b0;
        if (eta < eta_lo || eta > eta_hi) pass = 1'b0;
        if (phi < phi_lo || phi > phi_hi) pass = 1'b0;
        return pass;
    endfunction

    // Everything is sampled at the falling edge, away from the rising edge at which
    // the transaction completes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            eta_lo  = -524288;  eta_hi = 524287;
            phi_lo  = -25736;   phi_hi = 25736;
            mom_lo  = 0;        mom_hi = 64'h1_FFFF_FFFF;
            rad_lim = 64'hFFFF_FFFF;
            code0   = 0;        code1  = 0;
            accept_q.delete();
            o_errors   = 0;
            o_n_pass   = 0;
            o_n_reject = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (accept_q.size() == 0) begin
                    $display("%0t: result without transaction: expected none, got %0b",
                             $time, i_accepted);
                    o_errors++;
                end else begin
                    if (accept_q[0] !== i_accepted) begin
                        $display("%0t: accepted mismatch: expected %0b, got %0b",
                                 $time, accept_q[0], i_accepted);
                        o_errors++;
                    end
                    if (accept_q[0]) o_n_pass++;
                    else             o_n_reject++;
                    void'(accept_q.pop_front());
                end
            end
            if (i_valid && !i_in_stall)
                accept_q.push_back(particle_passes(i_mom_x, i_mom_y, i_mom_z,
                                                   i_particle_code, i_vertex_present,
                                                   i_vertex_x, i_vertex_y));
            if (i_cfg_we) begin
                case (pkcf_pkg::t_cfg_idx'(i_cfg_idx))
                    pkcf_pkg::CFG_ETA_LOW:   eta_lo  = longint'($signed(i_cfg_data[19:0]));
                    pkcf_pkg::CFG_ETA_HIGH:  eta_hi  = longint'($signed(i_cfg_data[19:0]));
                    pkcf_pkg::CFG_PHI_LOW:   phi_lo  = longint'($signed(i_cfg_data[15:0]));
                    pkcf_pkg::CFG_PHI_HIGH:  phi_hi  = longint'($signed(i_cfg_data[15:0]));
                    pkcf_pkg::CFG_MOM_LOW:   mom_lo  = {31'd0, i_cfg_data[32:0]};
                    pkcf_pkg::CFG_MOM_HIGH:  mom_hi  = {31'd0, i_cfg_data[32:0]};
                    pkcf_pkg::CFG_RADIUS:    rad_lim = {32'd0, i_cfg_data[31:0]};
                    pkcf_pkg::CFG_CODE_PAIR: begin
                        code0 = i_cfg_data[31:0];
                        code1 = i_cfg_data[63:32];
                    end
                    default: ;
                endcase
            end
        end
        o_pending = accept_q.size();
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives particles and cut settings into the kinematic cut filter under
// bursty input and random output back-pressure; the checker predicts and
// compares every accept flag.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LATENCY   = pkcf_pkg::CORDIC_STEPS_DEF + 52;
    localparam int IDLE_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_mom_x = '0, i_mom_y = '0, i_mom_z = '0;
    logic signed [31:0] i_particle_code = '0, i_vertex_x = '0, i_vertex_y = '0;
    logic        i_vertex_present = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_accepted;

    int          errors, pending, n_pass, n_reject;
    int          n_sent, idle_cycles;
    bit          long_hold_go;
    logic [31:0] code_a, code_b;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    particle_kinematic_cut_filter dut (.*);

    pkcf_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_in_stall(o_stall),
        .i_mom_x, .i_mom_y, .i_mom_z, .i_particle_code,
        .i_vertex_present, .i_vertex_x, .i_vertex_y,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_accepted(o_accepted),
        .o_errors(errors), .o_pending(pending),
        .o_n_pass(n_pass), .o_n_reject(n_reject)
    );

    // Receiver: stall density drifts with its own cycle count; a request
    // from the stimulus starts one long hold-off.
    int unsigned rx_cycle;
    int          hold_left;
    bit          hold_seen;
    always @(posedge i_clk) begin
        rx_cycle++;
        if (long_hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 400;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            case (rx_cycle[10:9])
                2'd0:    i_stall <= 1'b0;
                2'd1:    i_stall <= ($urandom_range(99) < 25);
                2'd2:    i_stall <= ($urandom_range(99) < 70);
                default: i_stall <= ($urandom_range(99) < 45);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input pkcf_pkg::t_cfg_idx idx, input logic [63:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Offers one particle and returns once it has been taken. Valid stays
    // high between back-to-back transactions.
    task automatic offer(input logic [31:0] mx, my, mz, code,
                         input logic vp, input logic [31:0] vx, vy);
        bit st;
        i_valid          <= 1'b1;
        i_mom_x          <= mx;
        i_mom_y          <= my;
        i_mom_z          <= mz;
        i_particle_code  <= code;
        i_vertex_present <= vp;
        i_vertex_x       <= vx;
        i_vertex_y       <= vy;
        do begin
            @(negedge i_clk);
            st = o_stall;
            @(posedge i_clk);
        end while (st);
        n_sent++;
    endtask

    task automatic pause(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(9))
            0:       return 32'd0;
            1, 2:    return $urandom;
            3:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4, 5:    return 32'(int'($urandom_range(2000)) - 1000);
            6:       return 32'(int'($urandom_range(2000000)) - 1000000);
            default: return 32'(int'($urandom_range(40000)) - 20000);
        endcase
    endfunction

    function automatic logic [31:0] rand_code();
        case ($urandom_range(5))
            0, 1:    return code_a;
            2:       return code_b;
            3:       return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_cuts(input int el, eh, pl, ph, input logic [63:0] ml, mh,
                            input logic [63:0] rl, input logic [31:0] ca, cb);
        write_reg(pkcf_pkg::CFG_ETA_LOW,   64'(el));
        write_reg(pkcf_pkg::CFG_ETA_HIGH,  64'(eh));
        write_reg(pkcf_pkg::CFG_PHI_LOW,   64'(pl));
        write_reg(pkcf_pkg::CFG_PHI_HIGH,  64'(ph));
        write_reg(pkcf_pkg::CFG_MOM_LOW,   ml);
        write_reg(pkcf_pkg::CFG_MOM_HIGH,  mh);
        write_reg(pkcf_pkg::CFG_RADIUS,    rl);
        write_reg(pkcf_pkg::CFG_CODE_PAIR, {cb, ca});
        code_a = ca;
        code_b = cb;
    endtask

    task automatic random_burst_run(input int count, input bit with_hold);
        int burst;
        logic [31:0] r;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(30, 1);
                if ($urandom_range(3) != 0) pause($urandom_range(12, 1));
            end
            burst--;
            if (with_hold && n == count / 3) long_hold_go = 1'b1;
            r = $urandom_range(3);
            offer(rand_comp(), rand_comp(), rand_comp(), rand_code(), r[0] | r[1],
                  r[1] ? $urandom : 32'(int'($urandom_range(4000)) - 2000),
                  r[1] ? $urandom : 32'(int'($urandom_range(4000)) - 2000));
        end
        pause(1);
    endtask

    initial begin
        code_a = 0;
        code_b = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Default cuts: zero momentum, purely longitudinal momentum, extreme
        // components, each azimuth quadrant and vertices inside the radius.
        offer(0, 0, 0, 0, 0, 0, 0);
        offer(0, 0, 1000, 11, 0, 0, 0);
        offer(0, 0, -1000, 11, 0, 0, 0);
        offer(0, 0, 32'h8000_0000, 22, 0, 0, 0);
        offer(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        offer(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        offer(-500, 10, 3, 1, 0, 0, 0);
        offer(-500, -10, 3, 1, 0, 0, 0);
        offer(-500, 0, 0, 1, 0, 0, 0);
        offer(500, -10, -3, 1, 0, 0, 0);
        offer(1, 0, 32'h7FFF_FFFF, 1, 0, 0, 0);
        offer(1, 0, 32'h8000_0001, 1, 0, 0, 0);
        offer(-700, -1, 0, 5, 1, 32'h8000_0000, 32'h8000_0000);
        offer(-700, -1, 0, 5, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        pause(1);
        drain();

        // Tight windows with a code pair; vertex inside/outside the radius.
        set_cuts(-8192, 8192, -12868, 12868, 100, 1000000, 1000, 11, -13);
        offer(300, 400, 0, 11, 1, 600, 800);
        offer(300, 400, 0, 11, 1, 600, 801);
        offer(300, 400, 0, -13, 0, 0, 0);
        offer(300, 400, 0, 12, 0, 0, 0);
        offer(60, 80, 0, 11, 0, 0, 0);
        offer(600, 800, 0, 11, 0, 0, 0);
        offer(6, 8, 0, 11, 0, 0, 0);
        random_burst_run(100, 1'b0);
        drain();

        // Inverted windows and extreme limits; only far vertices pass.
        set_cuts(524287, -524288, 32767, -32768, 64'h1_FFFF_FFFF, 0, 0,
                 32'h7FFF_FFFF, 32'h8000_0000);
        offer(0, 0, 0, 32'h7FFF_FFFF, 1, 0, 0);
        offer(0, 0, 0, 32'h8000_0000, 1, 1, 0);
        random_burst_run(80, 1'b0);
        drain();

        set_cuts(-524288, 524287, -32768, 32767, 0, 64'h1_FFFF_FFFF,
                 64'hFFFF_FFFF, 0, 0);
        random_burst_run(120, 1'b1);
        drain();

        set_cuts(0, 20000, 0, 32767, 500, 50000, 64'h8000_0000, 0, 211);
        random_burst_run(120, 1'b0);
        drain();

        set_cuts(int'($urandom_range(40000)) - 20000, int'($urandom_range(60000)),
                 int'($urandom_range(30000)) - 25736, int'($urandom_range(25736)),
                 $urandom_range(2000), 64'($urandom) << 1, $urandom,
                 $urandom, $urandom_range(1) ? 32'd0 : $urandom);
        random_burst_run(150, 1'b0);
        drain();

        $display("Sent %0d particles across six cut settings: %0d passed, %0d rejected.",
                 n_sent, n_pass, n_reject);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
